// File: hw/rtl/cmr_pkg.sv
// Shared types, constants and helpers of the CAN multiframe message reassembler.
// Used by cmr_lane_ram, cmr_slot_cell and can_multiframe_message_reassembler_unit.
// Depends on nothing.
package cmr_pkg;

    localparam int PENDING_SLOTS = 4;
    localparam int PAYLOAD_BYTES = 64;
    localparam int SLOT_W        = $clog2(PENDING_SLOTS);
    localparam int BEAT_LANES    = 8;
    localparam int ROW_W         = $clog2(PAYLOAD_BYTES / BEAT_LANES);
    localparam int RAM_AW        = SLOT_W + ROW_W;
    localparam int RAM_DEPTH     = 1 << RAM_AW;

    localparam logic [2:0] ST_WAITING   = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_LONG      = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_NO_SLOT   = 3'd4;
    localparam logic [2:0] ST_UNMATCHED = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_STREAM,
        S_DRAIN
    } fsm_t;

    // Frame information broadcast to every slot cell during decode.
    typedef struct packed {
        logic       clear;
        logic       start_en;
        logic       cont_en;
        logic [1:0] grp;
        logic [3:0] idx;
        logic [7:0] exp_len;
        logic [2:0] op;
        logic [5:0] dev;
        logic [5:0] fn;
        logic [2:0] start_fill;
        logic [3:0] cont_chunk;
    } bcast_t;

    // What one cell reports back to the controller.
    typedef struct packed {
        logic       sel;
        logic       claim;
        logic       cont_done;
        logic       wr_en;
        logic [6:0] wr_base;
        logic [3:0] wr_count;
        logic       active_next;
        logic [2:0] op;
        logic [5:0] dev;
        logic [5:0] fn;
        logic [7:0] exp_len;
    } cell_stat_t;

    // Zeroes every byte lane at or above cnt.
    function automatic logic [63:0] mask_bytes(input logic [63:0] w, input logic [3:0] cnt);
        logic [63:0] r;
        r = '0;
        for (int j = 0; j < BEAT_LANES; j++)
        begin
            if (4'(j) < cnt)
            begin
                r[8*j +: 8] = w[8*j +: 8];
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/can_multiframe_message_reassembler_unit.sv
// Top level of the CAN multiframe message reassembler.
// Depends on cmr_pkg, cmr_slot_cell and cmr_lane_ram.
//
// A frame or a clear command is taken in one transfer when start is high and
// busy is low. The block then decodes it and presents each result for exactly
// one cycle with result_valid high; the receiver cannot stall, so every result
// must be captured as it appears. A step that completes nothing, a short frame
// and a long message that completes on its first frame give one result,
// registered at the end of the decode step. A long message completed by a
// continuation is read back from the payload store one 8-byte beat per cycle,
// so its N beats (N at most eight) follow one another without a gap, and busy
// falls as the last beat is loaded; the store's single read port sets this
// rate. The pending slots form a row of four cells: the lowest free cell
// claims a long start and the highest matching cell takes a continuation,
// each decided by priority chains running through the row.
module can_multiframe_message_reassembler_unit
    import cmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [3:0]  frame_len,
    input  logic [63:0] frame_bytes,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [2:0]  msg_opcode,
    output logic [5:0]  msg_device,
    output logic [5:0]  msg_function,
    output logic [6:0]  msg_length,
    output logic [63:0] beat_bytes,
    output logic [3:0]  beat_count,
    output logic        last_beat,
    output logic [2:0]  pending_slots
);

    fsm_t state_reg, state_next;

    // Captured request.
    logic        req_reg;
    logic [3:0]  len_reg;
    logic [63:0] bytes_reg;

    // Completed message held while its beats are streamed.
    logic [2:0]        m_op_reg, m_op_next;
    logic [5:0]        m_dev_reg, m_dev_next;
    logic [5:0]        m_fn_reg, m_fn_next;
    logic [6:0]        m_len_reg, m_len_next;
    logic [ROW_W-1:0]  last_idx_reg, last_idx_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [2:0]        pend_reg, pend_next;
    logic [ROW_W-1:0]  issue_reg, issue_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [ROW_W-1:0]  rd_beat_reg, rd_beat_next;

    // Result registers.
    logic        strobe_reg, strobe_next;
    logic [2:0]  status_reg, status_next;
    logic [2:0]  op_reg, op_next;
    logic [5:0]  dev_reg, dev_next;
    logic [5:0]  fn_reg, fn_next;
    logic [6:0]  mlen_reg, mlen_next;
    logic [63:0] beat_reg, beat_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [2:0]  pslots_reg, pslots_next;

    bcast_t     bc;
    cell_stat_t st [PENDING_SLOTS];
    logic [PENDING_SLOTS:0] taken_chain;
    logic [PENDING_SLOTS:0] match_chain;
    logic [PENDING_SLOTS-1:0] sel_vec;

    logic [3:0]  dlc;
    logic [7:0]  b0, b1, b2, b3;
    logic        decoding;
    logic        any_wr, any_sel, any_done;
    logic [6:0]  wr_base;
    logic [3:0]  wr_count;
    logic [SLOT_W-1:0] wr_slot;
    logic [2:0]  src_off;
    logic [2:0]  c_op;
    logic [5:0]  c_dev, c_fn;
    logic [7:0]  c_exp;
    logic [2:0]  act_cnt;
    logic [6:0]  dlc_m2;
    logic [6:0]  beat_rem;
    logic [3:0]  beat_cnt;

    logic [BEAT_LANES-1:0] lane_we;
    logic [RAM_AW-1:0]     lane_waddr [BEAT_LANES];
    logic [7:0]            lane_wdata [BEAT_LANES];
    logic [RAM_AW-1:0]     raddr;
    logic [63:0]           rd_word;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg   <= req_type;
            len_reg   <= frame_len;
            bytes_reg <= frame_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            strobe_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            strobe_reg  <= strobe_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_op_reg     <= m_op_next;
        m_dev_reg    <= m_dev_next;
        m_fn_reg     <= m_fn_next;
        m_len_reg    <= m_len_next;
        last_idx_reg <= last_idx_next;
        slot_reg     <= slot_next;
        pend_reg     <= pend_next;
        issue_reg    <= issue_next;
        rd_beat_reg  <= rd_beat_next;
        status_reg   <= status_next;
        op_reg       <= op_next;
        dev_reg      <= dev_next;
        fn_reg       <= fn_next;
        mlen_reg     <= mlen_next;
        beat_reg     <= beat_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        pslots_reg   <= pslots_next;
    end

    // Frame fields and the broadcast to the cells.
    always_comb
    begin
        dlc      = (len_reg > 4'd8) ? 4'd8 : len_reg;
        b0       = bytes_reg[7:0];
        b1       = bytes_reg[15:8];
        b2       = bytes_reg[23:16];
        b3       = bytes_reg[31:24];
        decoding = (state_reg == S_DECODE);
        dlc_m2   = {3'b0, dlc} - 7'd2;

        bc.clear      = decoding & req_reg;
        bc.start_en   = decoding & ~req_reg & (dlc >= 4'd4) & b0[7] & ~b0[6];
        bc.cont_en    = decoding & ~req_reg & (dlc >= 4'd2) & b0[7] & b0[6];
        bc.grp        = b0[5:4];
        bc.idx        = b0[3:0];
        bc.exp_len    = b1;
        bc.op         = b2[6:4];
        bc.dev        = {b2[3:0], b3[7:6]};
        bc.fn         = b3[5:0];
        bc.start_fill = 3'(dlc - 4'd4);
        bc.cont_chunk = dlc - 4'd1;
    end

    assign taken_chain[0]             = 1'b0;
    assign match_chain[PENDING_SLOTS] = 1'b0;

    for (genvar g = 0; g < PENDING_SLOTS; g++)
    begin : g_cell
        cmr_slot_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bc        (bc),
            .taken_in  (taken_chain[g]),
            .taken_out (taken_chain[g+1]),
            .match_in  (match_chain[g+1]),
            .match_out (match_chain[g]),
            .st        (st[g])
        );
        assign sel_vec[g] = st[g].sel;
    end

    // Gather the report of whichever cell took the frame.
    always_comb
    begin
        any_wr   = 1'b0;
        any_sel  = 1'b0;
        any_done = 1'b0;
        wr_base  = '0;
        wr_count = '0;
        wr_slot  = '0;
        c_op     = '0;
        c_dev    = '0;
        c_fn     = '0;
        c_exp    = '0;
        act_cnt  = '0;
        for (int i = 0; i < PENDING_SLOTS; i++)
        begin
            act_cnt = act_cnt + {2'b0, st[i].active_next};
            if (st[i].sel || st[i].claim)
            begin
                any_wr   = st[i].wr_en;
                wr_base  = st[i].wr_base;
                wr_count = st[i].wr_count;
                wr_slot  = SLOT_W'(i);
            end
            if (st[i].sel)
            begin
                any_sel  = 1'b1;
                any_done = st[i].cont_done;
                c_op     = st[i].op;
                c_dev    = st[i].dev;
                c_fn     = st[i].fn;
                c_exp    = st[i].exp_len;
            end
        end
        src_off = (b0[6]) ? 3'd1 : 3'd4;
    end

    // Byte i of a chunk lands in lane (base + i) mod 8; a chunk never wraps onto
    // a lane twice, so all bytes of one frame are written in the same cycle.
    for (genvar l = 0; l < BEAT_LANES; l++)
    begin : g_lane
        logic [2:0] i3;
        logic [6:0] pos;
        logic [2:0] src;

        always_comb
        begin
            i3             = 3'(l) - wr_base[2:0];
            pos            = wr_base + {4'b0, i3};
            src            = src_off + i3;
            lane_we[l]     = any_wr & ({1'b0, i3} < wr_count);
            lane_waddr[l]  = {wr_slot, pos[ROW_W+2:3]};
            lane_wdata[l]  = bytes_reg[8*src +: 8];
        end

        cmr_lane_ram u_ram (
            .clk   (clk),
            .we    (lane_we[l]),
            .waddr (lane_waddr[l]),
            .wdata (lane_wdata[l]),
            .raddr (raddr),
            .rdata (rd_word[8*l +: 8])
        );
    end

    assign raddr = {slot_reg, issue_reg};

    always_comb
    begin
        beat_rem = m_len_reg - {1'b0, rd_beat_reg, 3'b0};
        beat_cnt = (beat_rem >= 7'd8) ? 4'd8 : beat_rem[3:0];
    end

    // Control sequence and result selection.
    always_comb
    begin
        state_next    = state_reg;
        m_op_next     = m_op_reg;
        m_dev_next    = m_dev_reg;
        m_fn_next     = m_fn_reg;
        m_len_next    = m_len_reg;
        last_idx_next = last_idx_reg;
        slot_next     = slot_reg;
        pend_next     = pend_reg;
        issue_next    = issue_reg;
        rd_pend_next  = 1'b0;
        rd_beat_next  = rd_beat_reg;

        strobe_next = 1'b0;
        status_next = status_reg;
        op_next     = op_reg;
        dev_next    = dev_reg;
        fn_next     = fn_reg;
        mlen_next   = mlen_reg;
        beat_next   = beat_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        pslots_next = pslots_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // Single result by default; message fields are zero.
                state_next  = S_IDLE;
                strobe_next = 1'b1;
                op_next     = '0;
                dev_next    = '0;
                fn_next     = '0;
                mlen_next   = '0;
                beat_next   = '0;
                cnt_next    = '0;
                last_next   = 1'b1;
                pslots_next = act_cnt;
                status_next = ST_WAITING;

                if (req_reg)
                begin
                    status_next = ST_CLEARED;
                end
                else if (dlc < 4'd2)
                begin
                    status_next = ST_TOO_SHORT;
                end
                else if (!b0[7])
                begin
                    status_next = ST_SHORT;
                    op_next     = b0[6:4];
                    dev_next    = {b0[3:0], b1[7:6]};
                    fn_next     = b1[5:0];
                    mlen_next   = dlc_m2;
                    beat_next   = mask_bytes({16'b0, bytes_reg[63:16]}, dlc_m2[3:0]);
                    cnt_next    = dlc_m2[3:0];
                end
                else if (!b0[6])
                begin
                    if (dlc < 4'd4)
                    begin
                        status_next = ST_TOO_SHORT;
                    end
                    else if (taken_chain[PENDING_SLOTS] == 1'b0)
                    begin
                        status_next = ST_NO_SLOT;
                    end
                    else if ({5'b0, bc.start_fill} >= bc.exp_len)
                    begin
                        // The whole message fits in the opening frame.
                        status_next = ST_LONG;
                        op_next     = bc.op;
                        dev_next    = bc.dev;
                        fn_next     = bc.fn;
                        mlen_next   = bc.exp_len[6:0];
                        beat_next   = mask_bytes({32'b0, bytes_reg[63:32]},
                                                 bc.exp_len[3:0]);
                        cnt_next    = bc.exp_len[3:0];
                    end
                end
                else if (!any_sel)
                begin
                    status_next = ST_UNMATCHED;
                end
                else if (any_done)
                begin
                    // Message completed by a continuation: stream it from the store.
                    strobe_next   = 1'b0;
                    state_next    = S_STREAM;
                    m_op_next     = c_op;
                    m_dev_next    = c_dev;
                    m_fn_next     = c_fn;
                    m_len_next    = c_exp[6:0];
                    last_idx_next = ROW_W'((c_exp[6:0] - 7'd1) >> 3);
                    slot_next     = wr_slot;
                    pend_next     = act_cnt;
                    issue_next    = '0;
                end
            end

            S_STREAM:
            begin
                rd_pend_next = 1'b1;
                rd_beat_next = issue_reg;
                issue_next   = issue_reg + ROW_W'(1);
                if (issue_reg == last_idx_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (rd_pend_reg && (rd_beat_reg == last_idx_reg))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rd_pend_reg)
        begin
            strobe_next = 1'b1;
            status_next = ST_LONG;
            op_next     = m_op_reg;
            dev_next    = m_dev_reg;
            fn_next     = m_fn_reg;
            mlen_next   = m_len_reg;
            beat_next   = mask_bytes(rd_word, beat_cnt);
            cnt_next    = beat_cnt;
            last_next   = (rd_beat_reg == last_idx_reg);
            pslots_next = pend_reg;
        end
    end

    assign result_valid  = strobe_reg;
    assign status        = status_reg;
    assign msg_opcode    = op_reg;
    assign msg_device    = dev_reg;
    assign msg_function  = fn_reg;
    assign msg_length    = mlen_reg;
    assign beat_bytes    = beat_reg;
    assign beat_count    = cnt_reg;
    assign last_beat     = last_reg;
    assign pending_slots = pslots_reg;

    // At most one cell may take a continuation.
    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_vec))
        else $error("more than one slot took a continuation");

    // Every result follows a cycle in which the block was working.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg != S_IDLE))
        else $error("result without a request in progress");

    // Only a long message completed by a continuation spans several beats.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_LONG) |-> last_beat)
        else $error("non-streamed result not marked last");

    // The pending count never exceeds the number of slots.
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_slots <= 3'(PENDING_SLOTS)))
        else $error("pending slot count out of range");

endmodule

// File: hw/rtl/cmr_lane_ram.sv
// One byte lane of the payload store: simple dual-port RAM with registered read.
// Depends on cmr_pkg for the address width and depth.
module cmr_lane_ram
    import cmr_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [RAM_AW-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [RAM_AW-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/cmr_slot_cell.sv
// One pending-message slot: holds the slot header and takes part in the
// free-slot and continuation-match priority chains. Depends on cmr_pkg.
module cmr_slot_cell
    import cmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bcast_t     bc,
    input  logic       taken_in,
    output logic       taken_out,
    input  logic       match_in,
    output logic       match_out,
    output cell_stat_t st
);

    logic       active_reg, active_next;
    logic [1:0] group_reg, group_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] op_reg, op_next;
    logic [5:0] dev_reg, dev_next;
    logic [5:0] fn_reg, fn_next;
    logic [7:0] exp_reg, exp_next;
    logic [6:0] filled_reg, filled_next;

    logic       claim, hit, sel, cont_wr, cont_done, start_done;
    logic [7:0] remaining, sum;
    logic [3:0] chunk;
    logic [6:0] filled_cont;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            group_reg  <= '0;
            idx_reg    <= '0;
            op_reg     <= '0;
            dev_reg    <= '0;
            fn_reg     <= '0;
            exp_reg    <= '0;
            filled_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            group_reg  <= group_next;
            idx_reg    <= idx_next;
            op_reg     <= op_next;
            dev_reg    <= dev_next;
            fn_reg     <= fn_next;
            exp_reg    <= exp_next;
            filled_reg <= filled_next;
        end
    end

    always_comb
    begin
        // The lowest free cell claims a long start; the highest matching cell
        // takes a continuation.
        claim     = bc.start_en & ~active_reg & ~taken_in;
        taken_out = taken_in | ~active_reg;
        hit       = active_reg && (group_reg == bc.grp) && (idx_reg == bc.idx)
                    && ({1'b0, filled_reg} < exp_reg);
        sel       = bc.cont_en & hit & ~match_in;
        match_out = match_in | hit;

        remaining   = exp_reg - {1'b0, filled_reg};
        chunk       = ({4'b0, bc.cont_chunk} > remaining) ? remaining[3:0] : bc.cont_chunk;
        sum         = {1'b0, filled_reg} + {4'b0, chunk};
        cont_wr     = (chunk != 4'd0) && (sum <= 8'(PAYLOAD_BYTES));
        filled_cont = cont_wr ? sum[6:0] : filled_reg;
        cont_done   = ({1'b0, filled_cont} >= exp_reg);
        start_done  = ({5'b0, bc.start_fill} >= bc.exp_len);

        active_next = active_reg;
        group_next  = group_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        dev_next    = dev_reg;
        fn_next     = fn_reg;
        exp_next    = exp_reg;
        filled_next = filled_reg;

        if (bc.clear)
        begin
            active_next = 1'b0;
            filled_next = '0;
        end
        else if (claim)
        begin
            active_next = ~start_done;
            group_next  = bc.grp;
            idx_next    = '0;
            op_next     = bc.op;
            dev_next    = bc.dev;
            fn_next     = bc.fn;
            exp_next    = bc.exp_len;
            filled_next = start_done ? 7'd0 : {4'b0, bc.start_fill};
        end
        else if (sel)
        begin
            idx_next = idx_reg + 4'd1;
            if (cont_done)
            begin
                active_next = 1'b0;
                filled_next = '0;
            end
            else
            begin
                filled_next = filled_cont;
            end
        end

        st.sel         = sel;
        st.claim       = claim;
        st.cont_done   = sel & cont_done;
        st.wr_en       = sel ? cont_wr : (claim & (bc.start_fill != 3'd0));
        st.wr_base     = sel ? filled_reg : 7'd0;
        st.wr_count    = sel ? chunk : {1'b0, bc.start_fill};
        st.active_next = active_next;
        st.op          = op_reg;
        st.dev         = dev_reg;
        st.fn          = fn_reg;
        st.exp_len     = exp_reg;
    end

endmodule
